[hw/rtl/hbm_pkg.sv]
// ----------------------------------------------------------------------------
// hbm_pkg
// Types, codes and defaults shared by the heartbeat monitor modules.
// ----------------------------------------------------------------------------
package hbm_pkg;

  localparam int unsigned CHANNELS_DEF     = 8;
  localparam logic [31:0] DEFAULT_DEADLINE = 32'd3000;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_BEAT  = 2'd1,
    CMD_ARM   = 2'd2,
    CMD_CHECK = 2'd3
  } hbm_cmd_t;

  typedef enum logic [1:0] {
    KIND_RESTORED = 2'd0,
    KIND_MISSED   = 2'd1,
    KIND_SUMMARY  = 2'd2
  } hbm_kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SWEEP,
    S_SUM
  } hbm_state_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  channel;
    logic [31:0] limit_ms;
    logic        mode_is_safe;
  } hbm_in_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [2:0] event_channel;
    logic       watchdog_fault;
    logic       enter_safe;
    logic       last;
  } hbm_out_t;

  typedef struct packed {
    logic load;
    logic tick;
    logic arm;
    logic beat;
    logic sw_clear;
    logic sw_step;
    logic summary;
  } hbm_ctl_t;

  typedef struct packed {
    hbm_cmd_t cmd;
    logic     ch_ok;
    logic     hit;
    logic     idx_last;
    logic     out_free;
  } hbm_stat_t;

endpackage

[hw/rtl/hbm_ctrl.sv]
// ----------------------------------------------------------------------------
// hbm_ctrl
// Sequencer that steps the datapath through one command word at a time.
// ----------------------------------------------------------------------------
module hbm_ctrl
  import hbm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  hbm_stat_t stat,
  output hbm_ctl_t  ctl
);

  hbm_state_t state_r;
  hbm_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat.cmd)
          CMD_TICK, CMD_ARM: state_nxt = S_IDLE;
          CMD_BEAT: begin
            if (stat.out_free || !stat.ch_ok) begin
              state_nxt = S_IDLE;
            end
          end
          CMD_CHECK: state_nxt = S_SWEEP;
          default:   state_nxt = S_IDLE;
        endcase
      end
      S_SWEEP: begin
        if ((stat.out_free || !stat.hit) && stat.idx_last) begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        ctl.load = in_valid;
      end
      S_EXEC: begin
        case (stat.cmd)
          CMD_TICK:  ctl.tick     = 1'b1;
          CMD_ARM:   ctl.arm      = stat.ch_ok;
          CMD_BEAT:  ctl.beat     = stat.ch_ok && stat.out_free;
          CMD_CHECK: ctl.sw_clear = 1'b1;
          default:   ctl.tick     = 1'b0;
        endcase
      end
      S_SWEEP: ctl.sw_step = stat.out_free || !stat.hit;
      S_SUM:   ctl.summary = stat.out_free;
      default: ctl         = '0;
    endcase
  end

endmodule

[hw/rtl/hbm_datapath.sv]
// ----------------------------------------------------------------------------
// hbm_datapath
// Channel tables, millisecond counter, sweep index and output register.
// ----------------------------------------------------------------------------
module hbm_datapath
  import hbm_pkg::*;
#(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  hbm_in_t   in_data,
  input  hbm_ctl_t  ctl,
  output hbm_stat_t stat,
  output logic      out_valid,
  input  logic      out_ready,
  output hbm_out_t  out_data
);

  localparam int unsigned IDXW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  hbm_in_t           q_r;
  logic [31:0]       now_r;
  logic [31:0]       last_beat_r [CHANNELS];
  logic [31:0]       deadline_r  [CHANNELS];
  logic [CHANNELS-1:0] armed_r;
  logic [CHANNELS-1:0] trip_r;
  logic [IDXW-1:0]   idx_r;
  logic              any_r;
  logic              out_valid_r;
  hbm_out_t          out_r;

  logic [31:0]     ch_ext;
  logic [IDXW-1:0] ch_idx;
  logic [31:0]     idx_ext;
  logic [31:0]     elapsed;
  logic            hit;

  assign ch_ext  = 32'(q_r.channel);
  assign ch_idx  = ch_ext[IDXW-1:0];
  assign idx_ext = 32'(idx_r);
  assign elapsed = now_r - last_beat_r[idx_r];
  assign hit     = armed_r[idx_r] && !trip_r[idx_r] && (elapsed > deadline_r[idx_r]);

  assign stat.cmd      = hbm_cmd_t'(q_r.cmd);
  assign stat.ch_ok    = ch_ext < 32'(CHANNELS);
  assign stat.hit      = hit;
  assign stat.idx_last = idx_r == IDXW'(CHANNELS - 1);
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r   <= '0;
      armed_r <= '0;
      trip_r  <= '0;
      idx_r   <= '0;
      any_r   <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        last_beat_r[i] <= '0;
        deadline_r[i]  <= DEFAULT_DEADLINE;
      end
    end else begin
      if (ctl.tick) begin
        now_r <= now_r + 32'd1;
      end
      if (ctl.arm) begin
        deadline_r[ch_idx]  <= q_r.limit_ms;
        armed_r[ch_idx]     <= 1'b1;
        last_beat_r[ch_idx] <= now_r;
      end
      if (ctl.beat) begin
        last_beat_r[ch_idx] <= now_r;
        trip_r[ch_idx]      <= 1'b0;
      end
      if (ctl.sw_clear) begin
        idx_r <= '0;
        any_r <= 1'b0;
      end
      if (ctl.sw_step) begin
        idx_r <= idx_r + IDXW'(1);
        if (hit) begin
          trip_r[idx_r] <= 1'b1;
          any_r         <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((ctl.beat && trip_r[ch_idx]) || (ctl.sw_step && hit) || ctl.summary) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.beat && trip_r[ch_idx]) begin
      out_r <= '{event_kind: KIND_RESTORED, event_channel: q_r.channel,
                 watchdog_fault: 1'b0, enter_safe: 1'b0, last: 1'b1};
    end else if (ctl.sw_step && hit) begin
      out_r <= '{event_kind: KIND_MISSED, event_channel: idx_ext[2:0],
                 watchdog_fault: 1'b0, enter_safe: 1'b0, last: 1'b0};
    end else if (ctl.summary) begin
      out_r <= '{event_kind: KIND_SUMMARY, event_channel: 3'd0,
                 watchdog_fault: any_r, enter_safe: any_r && !q_r.mode_is_safe,
                 last: 1'b1};
    end
  end

endmodule

[hw/rtl/multi_channel_heartbeat_monitor_core.sv]
// ----------------------------------------------------------------------------
// multi_channel_heartbeat_monitor_core
// Heartbeat watchdog over a set of channels with a tick-driven timebase.
//
//   Channel  Direction  Handshake          Word
//   in_      input      in_valid/in_ready  hbm_in_t (cmd, channel, deadline, mode)
//   out_     output     out_valid/out_ready hbm_out_t (event, channel, flags, last)
//
// Tick and arm words go through the execute state back to idle, as does a
// heartbeat while the output register is free; a heartbeat on a valid channel
// otherwise waits there until the older result leaves. A check sweep visits
// each channel in turn through the single elapsed-time compare, then emits the
// summary word. A new input word is taken while the last result still sits in
// the output register. A stalled output holds the sweep at the channel that
// trips. Reset is synchronous and resets all channel state.
// ----------------------------------------------------------------------------
module multi_channel_heartbeat_monitor_core
  import hbm_pkg::*;
#(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  hbm_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output hbm_out_t out_data
);

  hbm_ctl_t  ctl;
  hbm_stat_t stat;

  hbm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  hbm_datapath #(
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .ctl       (ctl),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
